[src/sei_pkg.sv]
`timescale 1ns / 1ps

package sei_pkg;

  // Coordinate format: signed Q10.10.
  localparam int COORD_WIDTH = 20;
  localparam int THR_WIDTH   = 63;

  // Derived datapath widths.
  localparam int DW     = COORD_WIDTH + 1;      // coordinate difference
  localparam int PW     = 2 * DW;               // product of two differences
  localparam int XW     = PW + 1;               // cross-product area
  localparam int CW     = XW + 2;               // three-term area sum
  localparam int DENW   = XW + 1;               // divisor
  localparam int HW     = (CW + 1) / 2;         // low half of an area magnitude
  localparam int NH     = (XW + 1) / 2;         // low half of the numerator area
  localparam int NW     = DW + XW;              // numerator of the division
  localparam int QB     = COORD_WIDTH;          // quotient bits
  localparam int PRODW  = 2 * CW;               // area-pair product

  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SEG_START_X  = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SEG_START_Y  = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SEG_END_X    = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SEG_END_Y    = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_AREA_THRESH  = 3'd4;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] edge_start_x;
    logic signed [COORD_WIDTH-1:0] edge_start_y;
    logic signed [COORD_WIDTH-1:0] edge_end_x;
    logic signed [COORD_WIDTH-1:0] edge_end_y;
  } edge_t;

  typedef struct packed {
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] cross_x;
    logic signed [COORD_WIDTH-1:0] cross_y;
    logic                          left_side;
  } result_t;

endpackage

[src/segment_edge_intersection.sv]
`timescale 1ns / 1ps

// Segment versus polygon edge intersection test.
//
// The query segment A-B and the area threshold are loaded through the
// configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data). The
// port is always ready, and it must only be written while no request is in
// flight. A threshold written as zero is stored as one.
// Each request on the input channel is one edge C-D. Every request
// produces exactly one result on the output channel: the hit flag, the
// crossing point and the side flag, or all zeros on a miss.
// Both data channels use valid and stall. A request is taken at an edge
// where valid is high and stall is low.
// The pipeline has seven arithmetic stages, one stage per quotient bit of the
// restoring divider (20 stages), and the output register. Throughput is one
// request per cycle while the output is not held by a stall.
// The whole pipeline holds while a result waits at the output and the
// receiver stalls, so in_stall follows that condition and nothing is lost.
// Reset clears all valid bits and returns the registers to A = B = 0 and a
// threshold of one.
module segment_edge_intersection (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  sei_pkg::edge_t                         in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output sei_pkg::result_t                       out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [sei_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [sei_pkg::THR_WIDTH-1:0]          cfg_data
);

  localparam int CWD  = sei_pkg::COORD_WIDTH;
  localparam int DW   = sei_pkg::DW;
  localparam int PW   = sei_pkg::PW;
  localparam int XW   = sei_pkg::XW;
  localparam int CW   = sei_pkg::CW;
  localparam int DENW = sei_pkg::DENW;
  localparam int HW   = sei_pkg::HW;
  localparam int NH   = sei_pkg::NH;
  localparam int NW   = sei_pkg::NW;
  localparam int QB   = sei_pkg::QB;
  localparam int PRW  = sei_pkg::PRODW;

  typedef struct packed {
    logic [DENW-1:0] rem_x;
    logic [QB-1:0]   low_x;
    logic [DENW-1:0] rem_y;
    logic [QB-1:0]   low_y;
    logic [DENW-1:0] dvs;
    logic            neg_x;
    logic            neg_y;
    logic            hit;
    logic            left;
  } div_t;

  typedef struct packed {
    logic [DENW-1:0] rem;
    logic [QB-1:0]   low;
  } step_t;

  // One restoring division step: bring down the next numerator bit.
  function automatic step_t div_step(input logic [DENW-1:0] rem,
                                     input logic [QB-1:0] low,
                                     input logic [DENW-1:0] dvs);
    logic [DENW:0] trial;
    step_t         r;
    trial = {rem, low[QB-1]};
    if (trial >= {1'b0, dvs}) begin
      r.rem = DENW'(trial - {1'b0, dvs});
      r.low = {low[QB-2:0], 1'b1};
    end else begin
      r.rem = trial[DENW-1:0];
      r.low = {low[QB-2:0], 1'b0};
    end
    return r;
  endfunction

  // Configuration registers.
  logic signed [CWD-1:0]             ax, ay, bx, by;
  logic [sei_pkg::THR_WIDTH-1:0]     thr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ax  <= '0;
      ay  <= '0;
      bx  <= '0;
      by  <= '0;
      thr <= sei_pkg::THR_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        sei_pkg::CFG_SEG_START_X: ax <= cfg_data[CWD-1:0];
        sei_pkg::CFG_SEG_START_Y: ay <= cfg_data[CWD-1:0];
        sei_pkg::CFG_SEG_END_X:   bx <= cfg_data[CWD-1:0];
        sei_pkg::CFG_SEG_END_Y:   by <= cfg_data[CWD-1:0];
        sei_pkg::CFG_AREA_THRESH: begin
          thr <= (cfg_data == '0) ? sei_pkg::THR_WIDTH'(1) : cfg_data;
        end
        default: ;
      endcase
    end
  end

  // The whole pipeline advances unless a finished result is held back.
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // Stage 1: differences u = C-A, v = D-A, w = B-A.
  logic                 v1;
  logic signed [DW-1:0] s1_ux, s1_uy, s1_vx, s1_vy, s1_wx, s1_wy;

  // Stage 2: the six products of the three cross products.
  logic                 v2;
  logic signed [PW-1:0] s2_wxuy, s2_uxwy, s2_wxvy, s2_vxwy, s2_uxvy, s2_vxuy;
  logic signed [DW-1:0] s2_wx, s2_wy;

  // Stage 3: areas abc = w x u, abd = w x v, cda = u x v.
  logic                 v3;
  logic signed [XW-1:0] s3_abc, s3_abd, s3_cda;
  logic signed [DW-1:0] s3_wx, s3_wy;

  // Stage 4: cdb = cda + abc - abd, divisor abd - abc, magnitudes, signs.
  logic                 v4;
  logic [CW-1:0]        s4_mabc, s4_mabd, s4_mcda, s4_mcdb;
  logic [DENW-1:0]      s4_dvs;
  logic [DW-1:0]        s4_mwx, s4_mwy;
  logic                 s4_opp_ab, s4_opp_cd, s4_neg_x, s4_neg_y, s4_left;

  logic signed [CW-1:0]   cdb_c;
  logic signed [DENW-1:0] den_c;
  assign cdb_c = CW'(s3_cda) + CW'(s3_abc) - CW'(s3_abd);
  assign den_c = DENW'(s3_abd) - DENW'(s3_abc);

  // Stage 5: partial products.
  logic                   v5;
  logic [2*HW-1:0]        s5_ab_ll, s5_ab_lh, s5_ab_hl, s5_ab_hh;
  logic [2*HW-1:0]        s5_cd_ll, s5_cd_lh, s5_cd_hl, s5_cd_hh;
  logic [DW+NH-1:0]       s5_nx_lo, s5_nx_hi, s5_ny_lo, s5_ny_hi;
  logic [DENW-1:0]        s5_dvs;
  logic                   s5_opp, s5_neg_x, s5_neg_y, s5_left;

  // Stage 6: full area products and division numerators.
  logic                   v6;
  logic [PRW-1:0]         s6_pab, s6_pcd;
  logic [NW-1:0]          s6_nx, s6_ny;
  logic [DENW-1:0]        s6_dvs;
  logic                   s6_opp, s6_neg_x, s6_neg_y, s6_left;

  // Stage 7 feeds the divider: dq[0]. Divider stage k is dq[k].
  logic                   dv [QB+1];
  div_t                   dq [QB+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      dv[0] <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      dv[0] <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ux <= DW'(in_data.edge_start_x) - DW'(ax);
      s1_uy <= DW'(in_data.edge_start_y) - DW'(ay);
      s1_vx <= DW'(in_data.edge_end_x) - DW'(ax);
      s1_vy <= DW'(in_data.edge_end_y) - DW'(ay);
      s1_wx <= DW'(bx) - DW'(ax);
      s1_wy <= DW'(by) - DW'(ay);

      s2_wxuy <= PW'(s1_wx) * PW'(s1_uy);
      s2_uxwy <= PW'(s1_ux) * PW'(s1_wy);
      s2_wxvy <= PW'(s1_wx) * PW'(s1_vy);
      s2_vxwy <= PW'(s1_vx) * PW'(s1_wy);
      s2_uxvy <= PW'(s1_ux) * PW'(s1_vy);
      s2_vxuy <= PW'(s1_vx) * PW'(s1_uy);
      s2_wx   <= s1_wx;
      s2_wy   <= s1_wy;

      s3_abc <= XW'(s2_wxuy) - XW'(s2_uxwy);
      s3_abd <= XW'(s2_wxvy) - XW'(s2_vxwy);
      s3_cda <= XW'(s2_uxvy) - XW'(s2_vxuy);
      s3_wx  <= s2_wx;
      s3_wy  <= s2_wy;

      s4_mabc   <= s3_abc[XW-1] ? CW'(-CW'(s3_abc)) : CW'(s3_abc);
      s4_mabd   <= s3_abd[XW-1] ? CW'(-CW'(s3_abd)) : CW'(s3_abd);
      s4_mcda   <= s3_cda[XW-1] ? CW'(-CW'(s3_cda)) : CW'(s3_cda);
      s4_mcdb   <= cdb_c[CW-1] ? CW'(-cdb_c) : CW'(cdb_c);
      s4_dvs    <= den_c[DENW-1] ? DENW'(-den_c) : DENW'(den_c);
      s4_mwx    <= s3_wx[DW-1] ? DW'(-s3_wx) : DW'(s3_wx);
      s4_mwy    <= s3_wy[DW-1] ? DW'(-s3_wy) : DW'(s3_wy);
      s4_opp_ab <= s3_abc[XW-1] != s3_abd[XW-1];
      s4_opp_cd <= s3_cda[XW-1] != cdb_c[CW-1];
      s4_neg_x  <= s3_wx[DW-1] ^ s3_cda[XW-1] ^ den_c[DENW-1];
      s4_neg_y  <= s3_wy[DW-1] ^ s3_cda[XW-1] ^ den_c[DENW-1];
      // (C-A) x (B-A) is the negated abc area.
      s4_left   <= s3_abc[XW-1];

      s5_ab_ll <= (2*HW)'(s4_mabc[HW-1:0]) * (2*HW)'(s4_mabd[HW-1:0]);
      s5_ab_lh <= (2*HW)'(s4_mabc[HW-1:0]) * (2*HW)'(s4_mabd[CW-1:HW]);
      s5_ab_hl <= (2*HW)'(s4_mabc[CW-1:HW]) * (2*HW)'(s4_mabd[HW-1:0]);
      s5_ab_hh <= (2*HW)'(s4_mabc[CW-1:HW]) * (2*HW)'(s4_mabd[CW-1:HW]);
      s5_cd_ll <= (2*HW)'(s4_mcda[HW-1:0]) * (2*HW)'(s4_mcdb[HW-1:0]);
      s5_cd_lh <= (2*HW)'(s4_mcda[HW-1:0]) * (2*HW)'(s4_mcdb[CW-1:HW]);
      s5_cd_hl <= (2*HW)'(s4_mcda[CW-1:HW]) * (2*HW)'(s4_mcdb[HW-1:0]);
      s5_cd_hh <= (2*HW)'(s4_mcda[CW-1:HW]) * (2*HW)'(s4_mcdb[CW-1:HW]);
      s5_nx_lo <= (DW+NH)'(s4_mwx) * (DW+NH)'(s4_mcda[NH-1:0]);
      s5_nx_hi <= (DW+NH)'(s4_mwx) * (DW+NH)'(s4_mcda[XW-1:NH]);
      s5_ny_lo <= (DW+NH)'(s4_mwy) * (DW+NH)'(s4_mcda[NH-1:0]);
      s5_ny_hi <= (DW+NH)'(s4_mwy) * (DW+NH)'(s4_mcda[XW-1:NH]);
      s5_dvs   <= s4_dvs;
      s5_opp   <= s4_opp_ab && s4_opp_cd;
      s5_neg_x <= s4_neg_x;
      s5_neg_y <= s4_neg_y;
      s5_left  <= s4_left;

      s6_pab <= (PRW'(s5_ab_hh) << (2*HW))
              + ((PRW'(s5_ab_lh) + PRW'(s5_ab_hl)) << HW) + PRW'(s5_ab_ll);
      s6_pcd <= (PRW'(s5_cd_hh) << (2*HW))
              + ((PRW'(s5_cd_lh) + PRW'(s5_cd_hl)) << HW) + PRW'(s5_cd_ll);
      s6_nx  <= (NW'(s5_nx_hi) << NH) + NW'(s5_nx_lo);
      s6_ny  <= (NW'(s5_ny_hi) << NH) + NW'(s5_ny_lo);
      s6_dvs   <= s5_dvs;
      s6_opp   <= s5_opp;
      s6_neg_x <= s5_neg_x;
      s6_neg_y <= s5_neg_y;
      s6_left  <= s5_left;

      // A zero area gives a zero product, which never reaches the
      // threshold, so the zero cases need no test of their own.
      dq[0].hit   <= s6_opp && (s6_pab >= PRW'(thr)) && (s6_pcd >= PRW'(thr));
      // On a hit the quotient is below 2^QB, so the upper numerator bits
      // are already smaller than the divisor.
      dq[0].rem_x <= s6_nx[NW-1:QB];
      dq[0].low_x <= s6_nx[QB-1:0];
      dq[0].rem_y <= s6_ny[NW-1:QB];
      dq[0].low_y <= s6_ny[QB-1:0];
      dq[0].dvs   <= s6_dvs;
      dq[0].neg_x <= s6_neg_x;
      dq[0].neg_y <= s6_neg_y;
      dq[0].left  <= s6_left;
    end
  end

  // Divider: one quotient bit per stage for each axis.
  for (genvar k = 1; k <= QB; k++) begin : g_div
    step_t sx, sy;
    assign sx = div_step(dq[k-1].rem_x, dq[k-1].low_x, dq[k-1].dvs);
    assign sy = div_step(dq[k-1].rem_y, dq[k-1].low_y, dq[k-1].dvs);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k] <= 1'b0;
      end else if (en) begin
        dv[k] <= dv[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq[k].rem_x <= sx.rem;
        dq[k].low_x <= sx.low;
        dq[k].rem_y <= sy.rem;
        dq[k].low_y <= sy.low;
        dq[k].dvs   <= dq[k-1].dvs;
        dq[k].neg_x <= dq[k-1].neg_x;
        dq[k].neg_y <= dq[k-1].neg_y;
        dq[k].hit   <= dq[k-1].hit;
        dq[k].left  <= dq[k-1].left;
      end
    end
  end

  // Output register: signed offset added to A, zeros on a miss.
  logic [CWD-1:0] off_x, off_y;
  assign off_x = dq[QB].neg_x ? CWD'(~dq[QB].low_x + 1'b1) : CWD'(dq[QB].low_x);
  assign off_y = dq[QB].neg_y ? CWD'(~dq[QB].low_y + 1'b1) : CWD'(dq[QB].low_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.hit       <= dq[QB].hit;
      out_data.cross_x   <= dq[QB].hit ? ax + off_x : '0;
      out_data.cross_y   <= dq[QB].hit ? ay + off_y : '0;
      out_data.left_side <= dq[QB].hit && dq[QB].left;
    end
  end

  // A miss always leaves the result fields at zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.hit |->
      out_data.cross_x == '0 && out_data.cross_y == '0 && !out_data.left_side)
    else $error("miss with nonzero result fields");

  // A hit entering the divider never has a zero divisor.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    dv[0] && dq[0].hit |-> dq[0].dvs != '0)
    else $error("hit with zero divisor");

  // While the output is held, the last divider stage and v6 do not move.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(dv[QB]) && $stable(dq[QB]) && $stable(v6))
    else $error("pipeline moved while held");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule
